// ----- rtl/tvwe_pkg.sv -----
// Shared types and constants for the tone voice with envelope.
package tvwe_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ATTACK_SAMPLES = 2'd0;
    localparam logic [1:0] CFG_ATTACK_GROWTH  = 2'd1;
    localparam logic [1:0] CFG_DECAY_FACTOR   = 2'd2;
    localparam logic [1:0] CFG_AMPLITUDE      = 2'd3;

    localparam int CFG_W = 18;

    // Configuration reset values.
    localparam logic [15:0] RST_ATTACK_SAMPLES = 16'd207;
    localparam logic [17:0] RST_ATTACK_GROWTH  = 18'd65756;
    localparam logic [15:0] RST_DECAY_FACTOR   = 16'd65529;
    localparam logic [14:0] RST_AMPLITUDE      = 15'd6000;

    // Envelope arithmetic, Q2.16.
    localparam logic [17:0] GROWTH_ONE = 18'd65536;
    localparam logic [17:0] GROWTH_MAX = 18'd262143;
    localparam logic [16:0] ENV_ONE    = 17'd65536;

    // Cosine table generation, Q30.
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // take the input request and set up the tick
        logic env_go; // envelope update step
        logic amp_go; // amplitude times cosine step
        logic mix_go; // envelope product, saturate, write output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_stall; // output register still holds an untaken sample
    } stat_t;

endpackage

// ----- rtl/tone_voice_with_envelope_top.sv -----
// Top level of the tone voice with envelope.
//
//  Channel  Direction  Payload                         Handshake
//  s_*      in         tuser: note_start; tdata: step  tvalid/tready
//  m_*      out        tdata: sample                   tvalid/tready
//  cfg_*    in         index, data                     cfg_we, no wait
//
// Each request passes through four steps: accept, envelope update, amplitude times
// cosine, envelope product with saturation. All three arithmetic steps share
// one multiplier, so the controller runs them one after another.
// The output register lets the next request be accepted while a sample waits.
// A stalled output holds the controller in its last step until the sample is taken.
// Reset restores the register defaults and the voice state; the cosine table is constant.
module tone_voice_with_envelope_top
#(
    parameter int TABLE_DEPTH = 256,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,  // [31:0] tone_step
    input  logic [0:0]                          s_tuser,  // [0] note_start
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,  // [SAMPLE_BITS-1:0] sample
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [tvwe_pkg::CFG_W-1:0]          cfg_data
);

    localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;

    tvwe_pkg::cmd_t  cmd;
    tvwe_pkg::stat_t stat;
    logic [SAMPLE_BITS-1:0] sample;

    tvwe_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tvwe_dp
    #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .note_start (s_tuser[0]),
        .tone_step  (s_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .sample     (sample)
    );

    assign m_tdata = OUT_W'(sample);

endmodule

// ----- rtl/tvwe_ctrl.sv -----
// Controller state machine that sequences the shared multiplier per tick.
module tvwe_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  tvwe_pkg::stat_t stat,
    output tvwe_pkg::cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENV,
        ST_AMP,
        ST_MIX
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_ENV;
                end
            end
            ST_ENV:
            begin
                cmd.env_go = 1'b1;
                state_next = ST_AMP;
            end
            ST_AMP:
            begin
                cmd.amp_go = 1'b1;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                // Hold here until the output register can take the sample.
                cmd.mix_go = !stat.out_stall;
                if (!stat.out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_env_then_amp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.env_go |=> cmd.amp_go)
        else $error("envelope step not followed by amplitude step");
`endif

endmodule

// ----- rtl/tvwe_dp.sv -----
// Datapath: configuration, phase and envelope state, cosine table, shared multiplier.
module tvwe_dp
#(
    parameter int TABLE_DEPTH = 256,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [tvwe_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         note_start,
    input  logic [31:0]                  tone_step,
    input  tvwe_pkg::cmd_t               cmd,
    output tvwe_pkg::stat_t              stat,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [SAMPLE_BITS-1:0]       sample
);

    localparam int KW = $clog2(TABLE_DEPTH);

    function automatic logic [TABLE_DEPTH*16-1:0] build_rom();
        logic [TABLE_DEPTH*16-1:0] rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] sub;
        logic [63:0] v;
        rom = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            x   = (tvwe_pkg::HALF_PI_Q30 * 64'(i)) / TABLE_DEPTH;
            x2  = (x * x) >> 30;
            t   = tvwe_pkg::Q30_ONE;
            // Horner form of the Taylor series, innermost term first.
            sub = ((x2 * t) >> 30) / 64'd132;
            t   = (sub >= tvwe_pkg::Q30_ONE) ? 64'd0 : tvwe_pkg::Q30_ONE - sub;
            sub = ((x2 * t) >> 30) / 64'd90;
            t   = (sub >= tvwe_pkg::Q30_ONE) ? 64'd0 : tvwe_pkg::Q30_ONE - sub;
            sub = ((x2 * t) >> 30) / 64'd56;
            t   = (sub >= tvwe_pkg::Q30_ONE) ? 64'd0 : tvwe_pkg::Q30_ONE - sub;
            sub = ((x2 * t) >> 30) / 64'd30;
            t   = (sub >= tvwe_pkg::Q30_ONE) ? 64'd0 : tvwe_pkg::Q30_ONE - sub;
            sub = ((x2 * t) >> 30) / 64'd12;
            t   = (sub >= tvwe_pkg::Q30_ONE) ? 64'd0 : tvwe_pkg::Q30_ONE - sub;
            sub = ((x2 * t) >> 30) / 64'd2;
            t   = (sub >= tvwe_pkg::Q30_ONE) ? 64'd0 : tvwe_pkg::Q30_ONE - sub;
            v   = (t * 64'd65535 + (tvwe_pkg::Q30_ONE >> 1)) >> 30;
            if (v > 64'd65535)
            begin
                v = 64'd65535;
            end
            rom[i*16 +: 16] = v[15:0];
        end
        return rom;
    endfunction

    localparam logic [TABLE_DEPTH*16-1:0] COS_ROM = build_rom();
    localparam logic [31:0] SAMPLE_LIMIT = (32'd1 << (SAMPLE_BITS - 1)) - 32'd1;

    // Configuration registers.
    logic [15:0] attack_samples_reg;
    logic [17:0] attack_growth_reg;
    logic [15:0] decay_factor_reg;
    logic [14:0] amplitude_reg;

    // Voice state.
    logic [31:0] phase_reg;
    logic [15:0] index_reg;
    logic [17:0] growth_reg;
    logic [16:0] env_reg;
    logic        attack_reg;
    logic        neg_reg;
    logic        rest_reg;
    logic [15:0] cmag_reg;
    logic [30:0] prod_reg;
    logic        out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_data_reg;

    // Tick setup.
    logic [31:0]   phase_eff;
    logic [15:0]   index_eff;
    logic [KW+1:0] k_idx;
    logic [1:0]    quad;
    logic [KW-1:0] r_idx;
    logic [KW-1:0] rom_idx;
    logic          mirror;
    logic [15:0]   rom_val;

    assign phase_eff = note_start ? 32'd0 : phase_reg;
    assign index_eff = note_start ? 16'd0 : index_reg;
    assign k_idx     = phase_eff[31 -: KW+2];
    assign quad      = k_idx[KW+1:KW];
    assign r_idx     = k_idx[KW-1:0];
    assign mirror    = quad[0];
    assign rom_idx   = mirror ? (KW'(0) - r_idx) : r_idx;
    assign rom_val   = (mirror && (r_idx == '0)) ? 16'd0 : COS_ROM[rom_idx*16 +: 16];

    // Shared multiplier with operand selection by step.
    logic [30:0] mul_a;
    logic [17:0] mul_b;
    logic [48:0] mul_p;

    always_comb
    begin
        if (cmd.env_go && attack_reg)
        begin
            mul_a = 31'(growth_reg);
            mul_b = attack_growth_reg;
        end
        else if (cmd.env_go)
        begin
            mul_a = 31'(env_reg);
            mul_b = 18'(decay_factor_reg);
        end
        else if (cmd.amp_go)
        begin
            mul_a = 31'(amplitude_reg);
            mul_b = 18'(cmag_reg);
        end
        else
        begin
            mul_a = prod_reg;
            mul_b = 18'(env_reg);
        end
    end

    assign mul_p = 49'(mul_a) * 49'(mul_b);

    // Attack envelope and growth update.
    logic [17:0] growth_excess;
    logic [16:0] env_attack;
    logic [36:0] growth_round;
    logic [20:0] growth_raw;
    logic [17:0] growth_sat;

    assign growth_excess = growth_reg - tvwe_pkg::GROWTH_ONE;
    assign env_attack    = (growth_reg <= tvwe_pkg::GROWTH_ONE) ? 17'd0 :
                           (growth_excess > 18'(tvwe_pkg::ENV_ONE)) ? tvwe_pkg::ENV_ONE :
                           growth_excess[16:0];
    assign growth_round  = mul_p[36:0] + 37'd32768;
    assign growth_raw    = growth_round[36:16];
    assign growth_sat    = (growth_raw > 21'(tvwe_pkg::GROWTH_MAX)) ?
                           tvwe_pkg::GROWTH_MAX : growth_raw[17:0];

    // Output magnitude, saturation and sign.
    logic [31:0] mag_ext;
    logic [31:0] mag_sat;
    logic [SAMPLE_BITS-1:0] mag_s;
    logic [SAMPLE_BITS-1:0] sample_next;

    assign mag_ext     = 32'(mul_p[47:32]);
    assign mag_sat     = (mag_ext > SAMPLE_LIMIT) ? SAMPLE_LIMIT : mag_ext;
    assign mag_s       = mag_sat[SAMPLE_BITS-1:0];
    assign sample_next = rest_reg ? '0 : (neg_reg ? (~mag_s + 1'b1) : mag_s);

    assign stat.out_stall = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_samples_reg <= tvwe_pkg::RST_ATTACK_SAMPLES;
            attack_growth_reg  <= tvwe_pkg::RST_ATTACK_GROWTH;
            decay_factor_reg   <= tvwe_pkg::RST_DECAY_FACTOR;
            amplitude_reg      <= tvwe_pkg::RST_AMPLITUDE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tvwe_pkg::CFG_ATTACK_SAMPLES: attack_samples_reg <= cfg_data[15:0];
                tvwe_pkg::CFG_ATTACK_GROWTH:  attack_growth_reg  <= cfg_data[17:0];
                tvwe_pkg::CFG_DECAY_FACTOR:   decay_factor_reg   <= cfg_data[15:0];
                tvwe_pkg::CFG_AMPLITUDE:      amplitude_reg      <= cfg_data[14:0];
                default:                      attack_samples_reg <= attack_samples_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            index_reg     <= '0;
            growth_reg    <= tvwe_pkg::GROWTH_ONE;
            env_reg       <= '0;
            attack_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                phase_reg  <= phase_eff + tone_step;
                index_reg  <= (index_eff == 16'hFFFF) ? index_eff : index_eff + 16'd1;
                attack_reg <= (index_eff <= attack_samples_reg);
                if (note_start)
                begin
                    growth_reg <= tvwe_pkg::GROWTH_ONE;
                    env_reg    <= '0;
                end
            end
            if (cmd.env_go)
            begin
                if (attack_reg)
                begin
                    env_reg    <= env_attack;
                    growth_reg <= growth_sat;
                end
                else
                begin
                    env_reg <= mul_p[32:16];
                end
            end
            if (cmd.mix_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmag_reg <= rom_val;
            neg_reg  <= (quad == 2'd1) || (quad == 2'd2);
            rest_reg <= (tone_step == 32'd0);
        end
        if (cmd.amp_go)
        begin
            prod_reg <= mul_p[30:0];
        end
        if (cmd.mix_go)
        begin
            out_data_reg <= sample_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = out_data_reg;

`ifndef NO_ASSERTIONS
    a_env_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        env_reg <= tvwe_pkg::ENV_ONE)
        else $error("envelope above one");
    a_note_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && note_start) |=>
            (growth_reg == tvwe_pkg::GROWTH_ONE) && (env_reg == '0) && attack_reg)
        else $error("note start did not restart the envelope");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mix_go |-> !(out_valid_reg && !out_ready))
        else $error("output register overwritten while stalled");
`endif

endmodule
